FILE: design/rrc_pkg.sv
// Shared constants for the rectangle rotation block.
`timescale 1ns / 1ps

package rrc_pkg;

  // Default field widths
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // Corner count and pipeline depth
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_CELLS   = 9;

  // Sine polynomial: the angle is widened to a 24-bit turn, folded into Q2.30
  localparam int unsigned TURN_BITS = 24;
  localparam int unsigned Z_BITS    = 31;
  localparam int unsigned Z_SHIFT   = 8;
  localparam int unsigned Q_FRAC    = 30;
  localparam int unsigned SIN_BITS  = 16;

  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [29:0] POLY_B  = 30'd688904866;
  localparam logic [26:0] POLY_C  = 27'd76016977;

  // Rounding of Q2.30 to Q1.15 and of the rotation sums
  localparam logic [14:0] ROUND_HALF = 15'd16384;
  localparam logic [14:0] SIN_MAX    = 15'h7fff;

endpackage

FILE: design/rrc_in_if.sv
// Input channel: four corners and an angle with valid/ready.
`timescale 1ns / 1ps

interface rrc_in_if #(
  parameter int unsigned COORD_BITS = rrc_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS = rrc_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] top_left_x;
  logic signed [COORD_BITS-1:0] top_left_y;
  logic signed [COORD_BITS-1:0] top_right_x;
  logic signed [COORD_BITS-1:0] top_right_y;
  logic signed [COORD_BITS-1:0] bottom_right_x;
  logic signed [COORD_BITS-1:0] bottom_right_y;
  logic signed [COORD_BITS-1:0] bottom_left_x;
  logic signed [COORD_BITS-1:0] bottom_left_y;
  logic        [ANGLE_BITS-1:0] angle;

  modport source (
    output valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y, angle,
    input  ready
  );

  modport sink (
    input  valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y, angle,
    output ready
  );
endinterface

FILE: design/rrc_out_if.sv
// Output channel: four rotated corners with valid/ready.
`timescale 1ns / 1ps

interface rrc_out_if #(
  parameter int unsigned COORD_BITS = rrc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_top_left_x;
  logic signed [COORD_BITS-1:0] out_top_left_y;
  logic signed [COORD_BITS-1:0] out_top_right_x;
  logic signed [COORD_BITS-1:0] out_top_right_y;
  logic signed [COORD_BITS-1:0] out_bottom_right_x;
  logic signed [COORD_BITS-1:0] out_bottom_right_y;
  logic signed [COORD_BITS-1:0] out_bottom_left_x;
  logic signed [COORD_BITS-1:0] out_bottom_left_y;

  modport source (
    output valid, out_top_left_x, out_top_left_y, out_top_right_x, out_top_right_y,
           out_bottom_right_x, out_bottom_right_y, out_bottom_left_x, out_bottom_left_y,
    input  ready
  );

  modport sink (
    input  valid, out_top_left_x, out_top_left_y, out_top_right_x, out_top_right_y,
           out_bottom_right_x, out_bottom_right_y, out_bottom_left_x, out_bottom_left_y,
    output ready
  );
endinterface

FILE: design/rect_rotate_about_center_top.sv
// Top level: rotates four corners about the midpoint of two opposite corners.
`timescale 1ns / 1ps

//  Channel | Dir | Modport          | Payload
//  --------+-----+------------------+-------------------------------------------
//  in_i    | in  | rrc_in_if.sink   | eight corner coordinates (Q16.16), angle
//  out_o   | out | rrc_out_if.source| eight rotated coordinates (Q16.16, saturated)
//
//  One item enters per cycle unless the chain is full behind a stalled output;
//  the chain is nine cells deep, and an item passes down it to the output register.
//  The sine/cosine polynomial needs four dependent multiplies, each in its own
//  cell, then rounding, the rotation multiplies, the sums and the saturation.
//  Reset clears only the valid bit of each cell; payload registers keep junk.
//  A stalled output holds its item; cells behind it keep filling until the
//  chain is full, and an empty cell takes the item of the cell before it.

module rect_rotate_about_center_top #(
  parameter int unsigned COORD_BITS = rrc_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS = rrc_pkg::ANGLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rrc_in_if.sink           in_i,
  rrc_out_if.source        out_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned NC = rrc_pkg::NUM_CORNERS;
  localparam int unsigned NS = rrc_pkg::NUM_CELLS;
  localparam int unsigned TB = rrc_pkg::TURN_BITS;
  localparam int unsigned ZB = rrc_pkg::Z_BITS;
  localparam int unsigned QF = rrc_pkg::Q_FRAC;
  localparam logic [TB-1:0] QUARTER = TB'(1) << (TB - 2);

  // One sine or cosine lane as it moves down the chain
  typedef struct packed {
    logic [1:0]                       quad;
    logic [ZB-1:0]                    z;
    logic [ZB-1:0]                    z2;
    logic [29:0]                      inner;
    logic [30:0]                      mid;
    logic [31:0]                      prod;
    logic [rrc_pkg::SIN_BITS-1:0]     val;
  } trig_t;

  // Everything one item carries; each cell fills in its own part
  typedef struct packed {
    logic [NC-1:0][CB-1:0]  x;
    logic [NC-1:0][CB-1:0]  y;
    logic [CB-1:0]          cx;
    logic [CB-1:0]          cy;
    logic [NC-1:0][CB:0]    dx;
    logic [NC-1:0][CB:0]    dy;
    trig_t                  sn;
    trig_t                  cs;
    logic [NC-1:0][CB+16:0] p_cdx;
    logic [NC-1:0][CB+16:0] p_sdy;
    logic [NC-1:0][CB+16:0] p_sdx;
    logic [NC-1:0][CB+16:0] p_cdy;
    logic [NC-1:0][CB+2:0]  rx;
    logic [NC-1:0][CB+2:0]  ry;
    logic [NC-1:0][CB-1:0]  ox;
    logic [NC-1:0][CB-1:0]  oy;
  } item_t;

  // Fold the turn into a first-quadrant Q2.30 argument
  function automatic trig_t trig_start(input logic [TB-1:0] t);
    trig_t          r;
    logic [ZB-1:0]  zr;
    r       = '0;
    r.quad  = t[TB-1:TB-2];
    zr      = ZB'(t[TB-3:0]) << rrc_pkg::Z_SHIFT;
    r.z     = r.quad[0] ? (rrc_pkg::ONE_Q30 - zr) : zr;
    return r;
  endfunction

  function automatic trig_t trig_sq(input trig_t a);
    trig_t       r;
    logic [61:0] p;
    r    = a;
    p    = 62'(a.z) * 62'(a.z);
    r.z2 = p[60:30];
    return r;
  endfunction

  function automatic trig_t trig_inner(input trig_t a);
    trig_t       r;
    logic [57:0] p;
    r       = a;
    p       = 58'(a.z2) * 58'(rrc_pkg::POLY_C);
    r.inner = rrc_pkg::POLY_B - 30'(p[57:QF]);
    return r;
  endfunction

  function automatic trig_t trig_mid(input trig_t a);
    trig_t       r;
    logic [60:0] p;
    r     = a;
    p     = 61'(a.z2) * 61'(a.inner);
    r.mid = rrc_pkg::POLY_A - p[60:QF];
    return r;
  endfunction

  function automatic trig_t trig_prod(input trig_t a);
    trig_t       r;
    logic [61:0] p;
    r      = a;
    p      = 62'(a.z) * 62'(a.mid);
    r.prod = p[61:QF];
    return r;
  endfunction

  // Round Q2.30 to Q1.15, clamp, and apply the sign of the half turn
  function automatic trig_t trig_round(input trig_t a);
    trig_t       r;
    logic [32:0] s;
    logic [17:0] mag;
    logic [14:0] m15;
    r   = a;
    s   = 33'(a.prod) + 33'(rrc_pkg::ROUND_HALF);
    mag = s[32:15];
    m15 = (mag[17:15] != 3'b000) ? rrc_pkg::SIN_MAX : mag[14:0];
    r.val = a.quad[1] ? (16'(0) - {1'b0, m15}) : {1'b0, m15};
    return r;
  endfunction

  // Saturate a widened sum to the coordinate width
  function automatic logic [CB-1:0] sat_coord(input logic [CB+3:0] v);
    logic [CB-1:0] r;
    if ((&v[CB+3:CB-1]) || !(|v[CB+3:CB-1])) begin
      r = v[CB-1:0];
    end else begin
      r = {v[CB+3], {(CB-1){~v[CB+3]}}};
    end
    return r;
  endfunction

  item_t         stg_d [NS];
  item_t         stg_q [NS];
  logic [NS-1:0] stg_v;
  logic [NS-1:0] stg_rdy;
  logic [TB-1:0] turn;
  logic [CB:0]   sum_x;
  logic [CB:0]   sum_y;

  // Widen the angle to a 24-bit turn and form the corner sums for the centre
  always_comb begin
    turn  = TB'(in_i.angle) << (TB - ANGLE_BITS);
    sum_x = {in_i.top_left_x[CB-1], in_i.top_left_x}
          + {in_i.bottom_right_x[CB-1], in_i.bottom_right_x};
    sum_y = {in_i.top_left_y[CB-1], in_i.top_left_y}
          + {in_i.bottom_right_y[CB-1], in_i.bottom_right_y};
  end

  always_comb begin
    // Cell 0: capture corners, fold the angle, halve the centre sums
    stg_d[0]      = '0;
    stg_d[0].x[0] = in_i.top_left_x;
    stg_d[0].y[0] = in_i.top_left_y;
    stg_d[0].x[1] = in_i.top_right_x;
    stg_d[0].y[1] = in_i.top_right_y;
    stg_d[0].x[2] = in_i.bottom_right_x;
    stg_d[0].y[2] = in_i.bottom_right_y;
    stg_d[0].x[3] = in_i.bottom_left_x;
    stg_d[0].y[3] = in_i.bottom_left_y;
    stg_d[0].cx   = sum_x[CB:1];
    stg_d[0].cy   = sum_y[CB:1];
    stg_d[0].sn   = trig_start(turn);
    stg_d[0].cs   = trig_start(turn + QUARTER);

    // Cell 1: square the argument, take offsets from the centre
    stg_d[1]    = stg_q[0];
    stg_d[1].sn = trig_sq(stg_q[0].sn);
    stg_d[1].cs = trig_sq(stg_q[0].cs);
    for (int i = 0; i < NC; i++) begin
      stg_d[1].dx[i] = {stg_q[0].x[i][CB-1], stg_q[0].x[i]}
                     - {stg_q[0].cx[CB-1], stg_q[0].cx};
      stg_d[1].dy[i] = {stg_q[0].y[i][CB-1], stg_q[0].y[i]}
                     - {stg_q[0].cy[CB-1], stg_q[0].cy};
    end

    // Cells 2 to 5: the polynomial, one multiply per cell, then rounding
    stg_d[2]    = stg_q[1];
    stg_d[2].sn = trig_inner(stg_q[1].sn);
    stg_d[2].cs = trig_inner(stg_q[1].cs);

    stg_d[3]    = stg_q[2];
    stg_d[3].sn = trig_mid(stg_q[2].sn);
    stg_d[3].cs = trig_mid(stg_q[2].cs);

    stg_d[4]    = stg_q[3];
    stg_d[4].sn = trig_prod(stg_q[3].sn);
    stg_d[4].cs = trig_prod(stg_q[3].cs);

    stg_d[5]    = stg_q[4];
    stg_d[5].sn = trig_round(stg_q[4].sn);
    stg_d[5].cs = trig_round(stg_q[4].cs);

    // Cell 6: the four rotation products of each corner
    stg_d[6] = stg_q[5];
    for (int i = 0; i < NC; i++) begin
      stg_d[6].p_cdx[i] = (CB+17)'($signed(stg_q[5].cs.val) * $signed(stg_q[5].dx[i]));
      stg_d[6].p_sdy[i] = (CB+17)'($signed(stg_q[5].sn.val) * $signed(stg_q[5].dy[i]));
      stg_d[6].p_sdx[i] = (CB+17)'($signed(stg_q[5].sn.val) * $signed(stg_q[5].dx[i]));
      stg_d[6].p_cdy[i] = (CB+17)'($signed(stg_q[5].cs.val) * $signed(stg_q[5].dy[i]));
    end

    // Cell 7: exact sums, rounded half up back to Q16.16
    stg_d[7] = stg_q[6];
    for (int i = 0; i < NC; i++) begin
      logic [CB+17:0] sx;
      logic [CB+17:0] sy;
      sx = (CB+18)'($signed(stg_q[6].p_cdx[i])) - (CB+18)'($signed(stg_q[6].p_sdy[i]))
         + (CB+18)'(rrc_pkg::ROUND_HALF);
      sy = (CB+18)'($signed(stg_q[6].p_sdx[i])) + (CB+18)'($signed(stg_q[6].p_cdy[i]))
         + (CB+18)'(rrc_pkg::ROUND_HALF);
      stg_d[7].rx[i] = sx[CB+17:15];
      stg_d[7].ry[i] = sy[CB+17:15];
    end

    // Cell 8: add the centre back and saturate
    stg_d[8] = stg_q[7];
    for (int i = 0; i < NC; i++) begin
      stg_d[8].ox[i] = sat_coord((CB+4)'($signed(stg_q[7].rx[i]))
                                 + (CB+4)'($signed(stg_q[7].cx)));
      stg_d[8].oy[i] = sat_coord((CB+4)'($signed(stg_q[7].ry[i]))
                                 + (CB+4)'($signed(stg_q[7].cy)));
    end
  end

  // The chain of cells; ready runs back from the output
  for (genvar k = 0; k < NS; k++) begin : g_cell
    logic up_valid;
    logic dn_ready;

    if (k == 0) begin : g_first
      assign up_valid = in_i.valid;
    end else begin : g_mid
      assign up_valid = stg_v[k-1];
    end

    if (k == NS - 1) begin : g_last
      assign dn_ready = out_o.ready;
    end else begin : g_inner
      assign dn_ready = stg_rdy[k+1];
    end

    rrc_cell #(
      .WIDTH ($bits(item_t))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (up_valid),
      .up_ready_o (stg_rdy[k]),
      .up_data_i  (stg_d[k]),
      .dn_valid_o (stg_v[k]),
      .dn_ready_i (dn_ready),
      .dn_data_o  (stg_q[k])
    );
  end

  assign in_i.ready = stg_rdy[0];

  assign out_o.valid              = stg_v[NS-1];
  assign out_o.out_top_left_x     = stg_q[NS-1].ox[0];
  assign out_o.out_top_left_y     = stg_q[NS-1].oy[0];
  assign out_o.out_top_right_x    = stg_q[NS-1].ox[1];
  assign out_o.out_top_right_y    = stg_q[NS-1].oy[1];
  assign out_o.out_bottom_right_x = stg_q[NS-1].ox[2];
  assign out_o.out_bottom_right_y = stg_q[NS-1].oy[2];
  assign out_o.out_bottom_left_x  = stg_q[NS-1].ox[3];
  assign out_o.out_bottom_left_y  = stg_q[NS-1].oy[3];

  // A full chain behind a stalled output must refuse new items
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&stg_v) && !out_o.ready) |-> !in_i.ready)
    else $error("chain full and stalled but input still ready");

  // The folded argument never exceeds one quarter turn
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v[1] |-> ((stg_q[1].sn.z2 <= rrc_pkg::ONE_Q30) && (stg_q[1].cs.z2 <= rrc_pkg::ONE_Q30)))
    else $error("squared argument above one");

  // The clamp keeps sine and cosine off the most negative code
  a_trig_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v[5] |-> ((stg_q[5].sn.val != 16'h8000) && (stg_q[5].cs.val != 16'h8000)))
    else $error("sine or cosine outside +/-32767");

  // An item moving into the output stage appears there on the next edge
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_v[NS-2] && stg_rdy[NS-1]) |=> out_o.valid)
    else $error("item lost between the last two cells");

endmodule

FILE: design/rrc_cell.sv
// One pipeline cell: holds one item and hands it to the next cell.
`timescale 1ns / 1ps

module rrc_cell #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  logic [WIDTH-1:0] up_data_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output logic [WIDTH-1:0] dn_data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // Take a new item when empty or when the held one leaves this cycle
  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: dv/rect_rotate_about_center_top_test.sv
// Self-checking test of the rectangle rotation block over its valid/ready channels.
`timescale 1ns / 1ps

module rect_rotate_about_center_top_test;

  localparam int CB = rrc_pkg::COORD_BITS_DEF;
  localparam int AB = rrc_pkg::ANGLE_BITS_DEF;
  localparam int NC = rrc_pkg::NUM_CORNERS;
  localparam int TB = rrc_pkg::TURN_BITS;

  localparam int RANDOM_SHAPES = 1720;
  localparam int FULL_RATE_SHAPES = 200;
  localparam int HOLD_SHAPES = 60;
  localparam int HOLD_CYCLES = 150;

  localparam int MAXI = 32'sh7fff_ffff;
  localparam int MINI = 32'sh8000_0000;
  localparam int ONE  = 32'sh0001_0000;

  // One shape as it enters, and the four corners as they leave; corner order is
  // top-left, top-right, bottom-right, bottom-left.
  typedef struct packed {
    logic [NC-1:0][CB-1:0] x;
    logic [NC-1:0][CB-1:0] y;
    logic [AB-1:0]         angle;
  } shape_t;

  typedef struct packed {
    logic [NC-1:0][CB-1:0] x;
    logic [NC-1:0][CB-1:0] y;
  } corners_t;

  // How the output side behaves for one run of cycles.
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_THIRD
  } sink_style_e;

  logic clk;
  logic rst_n;

  rrc_in_if  #(.COORD_BITS(CB), .ANGLE_BITS(AB)) in_ch ();
  rrc_out_if #(.COORD_BITS(CB))                  out_ch ();

  rect_rotate_about_center_top #(
    .COORD_BITS(CB),
    .ANGLE_BITS(AB)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Rotated corners still owed by the block, oldest first.
  corners_t pending_corners[$];

  string corner_label [NC] =
    '{"top_left", "top_right", "bottom_right", "bottom_left"};

  int errors;
  int shapes_sent;
  int results_checked;
  int saturated_coords;
  int quadrant_hits [4];

  // Output-side controls, written by the tests and read by the sink process.
  int hold_request;
  bit sink_free_run;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous guard: a correct run ends far sooner.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint coord(logic [CB-1:0] v);
    return longint'($signed(v));
  endfunction

  // Sine of a 24-bit turn in Q1.15: fold into the first quadrant as a Q2.30
  // fraction, evaluate the odd polynomial with truncating products, round to
  // Q1.15, clip at the positive limit and apply the sign of the half turn.
  function automatic longint turn_sine(logic [TB-1:0] t);
    logic [1:0]  q;
    logic [63:0] z, z2, inner, mid, s;
    q = t[TB-1 -: 2];
    z = 64'(t[TB-3:0]) << rrc_pkg::Z_SHIFT;
    if (q[0]) begin
      z = 64'(rrc_pkg::ONE_Q30) - z;
    end
    z2    = (z * z) >> rrc_pkg::Q_FRAC;
    inner = 64'(rrc_pkg::POLY_B) - ((z2 * 64'(rrc_pkg::POLY_C)) >> rrc_pkg::Q_FRAC);
    mid   = 64'(rrc_pkg::POLY_A) - ((z2 * inner) >> rrc_pkg::Q_FRAC);
    s     = (z * mid) >> rrc_pkg::Q_FRAC;
    s     = (s + 64'(rrc_pkg::ROUND_HALF)) >> (rrc_pkg::SIN_BITS - 1);
    if (s > 64'(rrc_pkg::SIN_MAX)) begin
      s = 64'(rrc_pkg::SIN_MAX);
    end
    return q[1] ? -longint'(s) : longint'(s);
  endfunction

  // Clip to the coordinate range and count how often that bites.
  function automatic logic [CB-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      saturated_coords++;
      return CB'(hi);
    end
    if (v < lo) begin
      saturated_coords++;
      return CB'(lo);
    end
    return CB'(v);
  endfunction

  // Rotate all four corners about the midpoint of top-left and bottom-right.
  // The sums are small enough to be exact in 64 bits, so round half up directly.
  function automatic corners_t rotate_shape(shape_t s);
    corners_t    r;
    logic [TB-1:0] t;
    longint      sn, cs, cx, cy, dx, dy, rx, ry;
    t  = TB'(s.angle) << (TB - AB);
    sn = turn_sine(t);
    cs = turn_sine(t + (TB'(1) << (TB - 2)));
    // Floor halving, as an arithmetic shift of the exact sum.
    cx = (coord(s.x[0]) + coord(s.x[2])) >>> 1;
    cy = (coord(s.y[0]) + coord(s.y[2])) >>> 1;
    for (int i = 0; i < NC; i++) begin
      dx = coord(s.x[i]) - cx;
      dy = coord(s.y[i]) - cy;
      rx = cs * dx - sn * dy + longint'(rrc_pkg::ROUND_HALF);
      ry = sn * dx + cs * dy + longint'(rrc_pkg::ROUND_HALF);
      rx = (rx >>> (rrc_pkg::SIN_BITS - 1)) + cx;
      ry = (ry >>> (rrc_pkg::SIN_BITS - 1)) + cy;
      r.x[i] = clamp_coord(rx);
      r.y[i] = clamp_coord(ry);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic shape_t quad(int tlx, int tly, int trx, int try_, int brx, int bry,
                                  int blx, int bly, int unsigned ang);
    shape_t s;
    s.x[0] = CB'(tlx);  s.y[0] = CB'(tly);
    s.x[1] = CB'(trx);  s.y[1] = CB'(try_);
    s.x[2] = CB'(brx);  s.y[2] = CB'(bry);
    s.x[3] = CB'(blx);  s.y[3] = CB'(bly);
    s.angle = AB'(ang);
    return s;
  endfunction

  // Mostly plausible rectangles of many sizes and positions; the rest raw bits,
  // tiny shapes, or corners hugging the limits so that the clipping is exercised.
  function automatic shape_t random_shape();
    shape_t s;
    int     kind, cx, cy, hw, hh;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int i = 0; i < NC; i++) begin
        s.x[i] = CB'($urandom);
        s.y[i] = CB'($urandom);
      end
    end else if (kind < 8) begin
      cx = int'($urandom) >>> $urandom_range(1, 12);
      cy = int'($urandom) >>> $urandom_range(1, 12);
      hw = int'($urandom_range(0, 32'h00ff_ffff) >> $urandom_range(0, 16));
      hh = int'($urandom_range(0, 32'h00ff_ffff) >> $urandom_range(0, 16));
      s  = quad(cx - hw, cy + hh, cx + hw, cy + hh, cx + hw, cy - hh, cx - hw, cy - hh, 0);
    end else if (kind == 8) begin
      for (int i = 0; i < NC; i++) begin
        s.x[i] = CB'(int'($urandom_range(0, 15)) - 8);
        s.y[i] = CB'(int'($urandom_range(0, 15)) - 8);
      end
    end else begin
      for (int i = 0; i < NC; i++) begin
        s.x[i] = $urandom_range(0, 1) ? CB'(MAXI - int'($urandom_range(0, 65535)))
                                      : CB'(MINI + int'($urandom_range(0, 65535)));
        s.y[i] = $urandom_range(0, 1) ? CB'(MAXI - int'($urandom_range(0, 65535)))
                                      : CB'(MINI + int'($urandom_range(0, 65535)));
      end
    end
    // Now and then land exactly on an eighth of a turn.
    if ($urandom_range(0, 7) == 0) begin
      s.angle = AB'($urandom_range(0, 7)) << (AB - 3);
    end else begin
      s.angle = AB'($urandom);
    end
    return s;
  endfunction

  // Offer one shape and hold it until the block takes it; valid stays high on
  // return so that a following call keeps the stream unbroken.
  task automatic send_shape(input shape_t s);
    in_ch.valid          <= 1'b1;
    in_ch.top_left_x     <= s.x[0];
    in_ch.top_left_y     <= s.y[0];
    in_ch.top_right_x    <= s.x[1];
    in_ch.top_right_y    <= s.y[1];
    in_ch.bottom_right_x <= s.x[2];
    in_ch.bottom_right_y <= s.y[2];
    in_ch.bottom_left_x  <= s.x[3];
    in_ch.bottom_left_y  <= s.y[3];
    in_ch.angle          <= s.angle;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_corners.push_back(rotate_shape(s));
    shapes_sent++;
    quadrant_hits[s.angle[AB-1 -: 2]]++;
  endtask

  // Drop valid for a number of cycles (at least one), with junk on top-left x and the angle.
  task automatic idle_for(input int cycles);
    in_ch.valid      <= 1'b0;
    in_ch.top_left_x <= CB'($urandom);
    in_ch.angle      <= AB'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been checked.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_corners.size() != 0);
  endtask

  task automatic report_error(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: one ready decision per cycle. A hold request takes priority
  // and is counted down here; otherwise either stay open (full-rate test) or
  // follow runs of random length, each with a style of its own.
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int          run_left;
    int          hold_left;
    sink_style_e style;
    run_left  = 0;
    hold_left = 0;
    style     = SINK_OPEN;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        style    = sink_style_e'($urandom_range(0, 2));
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_free_run) begin
        out_ch.ready <= 1'b1;
      end else begin
        case (style)
          SINK_OPEN: begin
            out_ch.ready <= 1'b1;
          end
          SINK_COIN: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ch.ready <= (run_left % 3 == 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every item leaving the block is matched with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    corners_t got, want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.x[0] = out_ch.out_top_left_x;
      got.y[0] = out_ch.out_top_left_y;
      got.x[1] = out_ch.out_top_right_x;
      got.y[1] = out_ch.out_top_right_y;
      got.x[2] = out_ch.out_bottom_right_x;
      got.y[2] = out_ch.out_bottom_right_y;
      got.x[3] = out_ch.out_bottom_left_x;
      got.y[3] = out_ch.out_bottom_left_y;
      if (pending_corners.size() == 0) begin
        report_error($sformatf("result with nothing outstanding, top_left_x %0d",
                               $signed(got.x[0])));
      end else begin
        want = pending_corners.pop_front();
        results_checked++;
        for (int i = 0; i < NC; i++) begin
          if (got.x[i] !== want.x[i]) begin
            report_error($sformatf("result %0d %s_x got %0d want %0d", results_checked,
                                   corner_label[i], $signed(got.x[i]), $signed(want.x[i])));
          end
          if (got.y[i] !== want.y[i]) begin
            report_error($sformatf("result %0d %s_y got %0d want %0d", results_checked,
                                   corner_label[i], $signed(got.y[i]), $signed(want.y[i])));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked shapes: nothing at all, a unit square through every quadrant
  // boundary, corners pinned to the limits, a centre whose halving must floor
  // a negative odd sum, a large square turned by an eighth of a turn, and random
  // corners either side of two quadrant seams and at three eighths of a turn.
  task automatic test_directed();
    int unsigned turns [8] = '{0, 1, 8192, 16384, 32768, 49152, 65535, 40000};
    int unsigned seams [5] = '{16383, 16385, 32767, 32769, 24576};
    send_shape(quad(0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (turns[i]) begin
      send_shape(quad(-ONE, ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE, turns[i]));
    end
    send_shape(quad(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, 32768));
    send_shape(quad(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, 16384));
    send_shape(quad(MAXI, MAXI, MAXI, MINI, MINI, MINI, MINI, MAXI, 32768));
    send_shape(quad(MINI, MAXI, MAXI, MAXI, MAXI, MINI, MINI, MINI, 16384));
    send_shape(quad(-3, -5, 7, -5, 0, 0, -3, 0, 16384));
    send_shape(quad(-(1 << 30), 1 << 30, 1 << 30, 1 << 30, 1 << 30, -(1 << 30),
                    -(1 << 30), -(1 << 30), 8192));
    foreach (seams[i]) begin
      send_shape(quad($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, seams[i]));
    end
    wait_all_results();
  endtask

  // Back-to-back items with the output always open: one item per cycle.
  task automatic test_full_rate();
    sink_free_run = 1'b1;
    repeat (FULL_RATE_SHAPES) send_shape(random_shape());
    wait_all_results();
    sink_free_run = 1'b0;
  endtask

  // Close the output for a long stretch while items keep coming, so that the
  // chain fills and the input stalls; then let it drain.
  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    repeat (HOLD_SHAPES) send_shape(random_shape());
    wait_all_results();
  endtask

  // Bulk of the run: bursts of random length, with random gaps between most of
  // them, against the output side's own stall pattern.
  task automatic test_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_SHAPES) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_SHAPES; i++) begin
        send_shape(random_shape());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
    end
    wait_all_results();
  endtask

  initial begin
    errors           = 0;
    shapes_sent      = 0;
    results_checked  = 0;
    saturated_coords = 0;
    quadrant_hits    = '{0, 0, 0, 0};
    hold_request     = 0;
    sink_free_run    = 1'b0;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.top_left_x     <= '0;
    in_ch.top_left_y     <= '0;
    in_ch.top_right_x    <= '0;
    in_ch.top_right_y    <= '0;
    in_ch.bottom_right_x <= '0;
    in_ch.bottom_right_y <= '0;
    in_ch.bottom_left_x  <= '0;
    in_ch.bottom_left_y  <= '0;
    in_ch.angle          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_rate();
    test_output_hold();
    test_random_traffic();

    // Leave time for any stray result to show up after the last one expected.
    repeat (rrc_pkg::NUM_CELLS + 10) @(posedge clk);

    $display("Summary: %0d shapes rotated and %0d results checked, %0d coordinates clipped.",
             shapes_sent, results_checked, saturated_coords);
    $display("Summary: angles per quadrant %0d/%0d/%0d/%0d, %s",
             quadrant_hits[0], quadrant_hits[1], quadrant_hits[2], quadrant_hits[3],
             "with full-rate, long-stall and drained phases.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/rrc_pkg.sv
design/rrc_in_if.sv
design/rrc_out_if.sv
design/rrc_cell.sv
design/rect_rotate_about_center_top.sv
dv/rect_rotate_about_center_top_test.sv
